// File: hdl/mcg_pkg.sv
`timescale 1ns / 1ps

package mcg_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_WR_ACCENT = 2'd0;
  localparam logic [1:0] REQ_WR_CLICK  = 2'd1;
  localparam logic [1:0] REQ_TICK      = 2'd2;
  localparam logic [1:0] REQ_RESTART   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_TEMPO_BPM   = 3'd0;
  localparam logic [2:0] REG_BEATS_PER_IV = 3'd1;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd2;
  localparam logic [2:0] REG_ACCENT_LEN  = 3'd3;
  localparam logic [2:0] REG_CLICK_LEN   = 3'd4;
  localparam logic [2:0] REG_SEP_ACCENT  = 3'd5;

  localparam int CFG_IDXW  = 3;
  localparam int CFG_DATAW = 18;

  // Register limits and reset values
  localparam logic [8:0]  BPM_MIN   = 9'd20;
  localparam logic [8:0]  BPM_MAX   = 9'd400;
  localparam logic [8:0]  BPM_RST   = 9'd120;
  localparam logic [6:0]  BPI_MIN   = 7'd1;
  localparam logic [6:0]  BPI_MAX   = 7'd64;
  localparam logic [6:0]  BPI_RST   = 7'd16;
  localparam logic [17:0] RATE_MIN  = 18'd8000;
  localparam logic [17:0] RATE_MAX  = 18'd192000;
  localparam logic [17:0] RATE_RST  = 18'd48000;

  // Period widths and reset values
  localparam int BEAT_W = 20;
  localparam int POS_W  = 26;
  localparam int CNT_W  = 6;
  localparam logic [BEAT_W-1:0] BEAT_PERIOD_RST = 20'd24000;
  localparam logic [POS_W-1:0]  IV_PERIOD_RST   = 26'd384000;
  localparam logic [CNT_W-1:0]  BEAT_CNT_MAX    = 6'd63;

  // Serial divider geometry
  localparam int DIV_NW   = 30;
  localparam int DIV_DW   = 20;
  localparam int DIV_CNTW = 5;
  localparam logic [DIV_CNTW-1:0] DIV_LAST = 5'd29;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

endpackage

// File: hdl/mcg_if.sv
`timescale 1ns / 1ps

interface mcg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [12:0]        clip_index;
  logic signed [15:0] clip_sample;

  modport source (output valid, output req_type, output clip_index, output clip_sample,
                  input ready);
  modport sink (input valid, input req_type, input clip_index, input clip_sample,
                output ready);
endinterface

interface mcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] audio_out;
  logic               is_accent;
  logic [5:0]         beat_number;
  logic               beat_start;

  modport source (output valid, output audio_out, output is_accent, output beat_number,
                  output beat_start, input ready);
  modport sink (input valid, input audio_out, input is_accent, input beat_number,
                input beat_start, output ready);
endinterface

// File: hdl/metronome_click_generator_top.sv
`timescale 1ns / 1ps
// A tick item accepted on in_ch passes stage 1 (clip memory read) and the output register to out_ch.
// Throughput: one item per cycle unless out_ch stalls or a recompute runs.
// After each configuration write the periods and beat offset are worked out again
// by a shared serial divider (three 30-step divides); in_ch.ready is low then.
// Reset (rst_n, synchronous, active low) restores the registers, periods and position;
// the clip memories are not cleared.

module metronome_click_generator_top #(
  parameter int CLIP_DEPTH = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mcg_pkg::CFG_IDXW-1:0]   cfg_index,
  input  logic [mcg_pkg::CFG_DATAW-1:0]  cfg_data,
  mcg_in_if.sink                         in_ch,
  mcg_out_if.source                      out_ch
);

  localparam int AW = $clog2(CLIP_DEPTH);
  localparam logic [20:0] DEPTH_LIM = 21'(CLIP_DEPTH);

  // Period sequencer
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,  // 60 * rate
    ST_MUL2  = 6'b000100,  // times beats per interval, start beat divide
    ST_DBEAT = 6'b001000,  // wait beat period
    ST_DINT  = 6'b010000,  // wait interval period
    ST_DPOS  = 6'b100000   // wait position / beat period
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  // Configuration registers
  logic [8:0]  bpm_r;
  logic [6:0]  bpi_r;
  logic [17:0] rate_r;
  logic [13:0] acc_len_r;
  logic [13:0] clk_len_r;
  logic        sep_r;

  logic [8:0]  bpm_c;
  logic [6:0]  bpi_c;
  logic [17:0] rate_c;

  logic [23:0] num_beat_r, num_beat_nxt;
  logic [29:0] num_int_r, num_int_nxt;

  logic [mcg_pkg::BEAT_W-1:0] beat_period_r, beat_period_nxt;
  logic [mcg_pkg::POS_W-1:0]  iv_period_r, iv_period_nxt;

  // Interval position state
  logic [mcg_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [mcg_pkg::BEAT_W-1:0] offset_r, offset_nxt;
  logic [mcg_pkg::CNT_W-1:0]  count_r, count_nxt;

  mcg_pkg::div_req_t div_req;
  mcg_pkg::div_rsp_t div_rsp;

  // Handshake and pipeline
  logic accept;
  logic tick_acc;
  logic out_free;
  logic s1_free;
  logic busy;

  logic        s1_v_r;
  logic        s1_use_acc_r;
  logic        s1_hit_r;
  logic        s1_accent_r;
  logic [5:0]  s1_beat_r;
  logic        s1_start_r;

  logic               out_v_r;
  logic signed [15:0] out_audio_r;
  logic               out_accent_r;
  logic [5:0]         out_beat_r;
  logic               out_start_r;

  // Clip memories
  logic [15:0] accent_mem [CLIP_DEPTH];
  logic [15:0] click_mem  [CLIP_DEPTH];
  logic [15:0] acc_rd_r;
  logic [15:0] clk_rd_r;
  logic        wr_ok;
  logic        acc_we;
  logic        clk_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Tick decode
  logic        accent_beat;
  logic        use_acc;
  logic [13:0] len_sel;
  logic        hit;
  logic [mcg_pkg::POS_W:0] pos_inc;

  assign busy     = (state_r != ST_IDLE);
  assign out_free = !out_v_r || out_ch.ready;
  assign s1_free  = !s1_v_r || out_free;
  assign in_ch.ready = !busy && s1_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign tick_acc = accept && (in_ch.req_type == mcg_pkg::REQ_TICK);

  // Clamp registers into their legal ranges before the period math
  always_comb begin
    bpm_c  = (bpm_r < mcg_pkg::BPM_MIN) ? mcg_pkg::BPM_MIN :
             (bpm_r > mcg_pkg::BPM_MAX) ? mcg_pkg::BPM_MAX : bpm_r;
    bpi_c  = (bpi_r < mcg_pkg::BPI_MIN) ? mcg_pkg::BPI_MIN :
             (bpi_r > mcg_pkg::BPI_MAX) ? mcg_pkg::BPI_MAX : bpi_r;
    rate_c = (rate_r < mcg_pkg::RATE_MIN) ? mcg_pkg::RATE_MIN :
             (rate_r > mcg_pkg::RATE_MAX) ? mcg_pkg::RATE_MAX : rate_r;
  end

  // Configuration writes; any write restarts the period sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_r     <= mcg_pkg::BPM_RST;
      bpi_r     <= mcg_pkg::BPI_RST;
      rate_r    <= mcg_pkg::RATE_RST;
      acc_len_r <= '0;
      clk_len_r <= '0;
      sep_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcg_pkg::REG_TEMPO_BPM:    bpm_r     <= cfg_data[8:0];
        mcg_pkg::REG_BEATS_PER_IV: bpi_r     <= cfg_data[6:0];
        mcg_pkg::REG_SAMPLE_RATE:  rate_r    <= cfg_data[17:0];
        mcg_pkg::REG_ACCENT_LEN:   acc_len_r <= cfg_data[13:0];
        mcg_pkg::REG_CLICK_LEN:    clk_len_r <= cfg_data[13:0];
        mcg_pkg::REG_SEP_ACCENT:   sep_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: beat period, interval period, then re-place the position
  always_comb begin
    state_nxt       = state_r;
    num_beat_nxt    = num_beat_r;
    num_int_nxt     = num_int_r;
    beat_period_nxt = beat_period_r;
    iv_period_nxt   = iv_period_r;
    div_req.start   = 1'b0;
    div_req.num     = 30'(num_beat_r);
    div_req.den     = 20'(bpm_c);
    unique case (state_r)
      ST_IDLE: ;
      ST_MUL: begin
        num_beat_nxt = 24'({6'd0, rate_c} * 24'd60);
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        num_int_nxt   = 30'({6'd0, num_beat_r} * 30'(bpi_c));
        div_req.start = 1'b1;
        state_nxt     = ST_DBEAT;
      end
      ST_DBEAT: begin
        if (div_rsp.done) begin
          beat_period_nxt = div_rsp.quot[mcg_pkg::BEAT_W-1:0];
          div_req.start   = 1'b1;
          div_req.num     = num_int_r;
          state_nxt       = ST_DINT;
        end
      end
      ST_DINT: begin
        if (div_rsp.done) begin
          iv_period_nxt = div_rsp.quot[mcg_pkg::POS_W-1:0];
          div_req.start = 1'b1;
          div_req.num   = 30'(pos_r);
          div_req.den   = beat_period_r;
          state_nxt     = ST_DPOS;
        end
      end
      ST_DPOS: begin
        if (div_rsp.done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_we) state_nxt = ST_MUL;
  end

  mcg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Tick decode from the current position
  always_comb begin
    accent_beat = (count_r == '0);
    use_acc     = accent_beat && sep_r;
    len_sel     = use_acc ? acc_len_r : clk_len_r;
    hit         = ({1'b0, offset_r} < 21'(len_sel)) && ({1'b0, offset_r} < DEPTH_LIM);
    raddr       = offset_r[AW-1:0];
    pos_inc     = {1'b0, pos_r} + 1'b1;
  end

  // Position update: incremental on ticks, cleared on restart, from the divider after a reconfig
  always_comb begin
    pos_nxt    = pos_r;
    offset_nxt = offset_r;
    count_nxt  = count_r;
    if (accept) begin
      case (in_ch.req_type)
        mcg_pkg::REQ_TICK: begin
          if (pos_inc >= {1'b0, iv_period_r}) begin
            pos_nxt    = '0;
            offset_nxt = '0;
            count_nxt  = '0;
          end else begin
            pos_nxt = pos_inc[mcg_pkg::POS_W-1:0];
            if (offset_r + 1'b1 == beat_period_r) begin
              offset_nxt = '0;
              count_nxt  = (count_r == mcg_pkg::BEAT_CNT_MAX) ? count_r : count_r + 1'b1;
            end else begin
              offset_nxt = offset_r + 1'b1;
            end
          end
        end
        mcg_pkg::REQ_RESTART: begin
          pos_nxt    = '0;
          offset_nxt = '0;
          count_nxt  = '0;
        end
        default: ;
      endcase
    end else if (state_r == ST_DPOS && div_rsp.done) begin
      offset_nxt = div_rsp.rem;
      count_nxt  = (div_rsp.quot > 30'(mcg_pkg::BEAT_CNT_MAX)) ?
                   mcg_pkg::BEAT_CNT_MAX : div_rsp.quot[mcg_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      beat_period_r <= mcg_pkg::BEAT_PERIOD_RST;
      iv_period_r   <= mcg_pkg::IV_PERIOD_RST;
      pos_r         <= '0;
      offset_r      <= '0;
      count_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      beat_period_r <= beat_period_nxt;
      iv_period_r   <= iv_period_nxt;
      pos_r         <= pos_nxt;
      offset_r      <= offset_nxt;
      count_r       <= count_nxt;
    end
    num_beat_r <= num_beat_nxt;
    num_int_r  <= num_int_nxt;
  end

  // Clip table writes; out-of-depth indexes are dropped
  assign wr_ok  = 17'(in_ch.clip_index) < 17'(CLIP_DEPTH);
  assign acc_we = accept && wr_ok && (in_ch.req_type == mcg_pkg::REQ_WR_ACCENT);
  assign clk_we = accept && wr_ok && (in_ch.req_type == mcg_pkg::REQ_WR_CLICK);
  assign waddr  = AW'(in_ch.clip_index);

  always_ff @(posedge clk) begin
    if (acc_we) accent_mem[waddr] <= in_ch.clip_sample;
    if (clk_we) click_mem[waddr]  <= in_ch.clip_sample;
  end

  // Registered reads, only on a tick so the data holds while stage 1 waits
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      acc_rd_r <= accent_mem[raddr];
      clk_rd_r <= click_mem[raddr];
    end
  end

  // Stage 1 (memory data) and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= tick_acc;
      if (out_free) out_v_r <= s1_v_r;
    end
    if (tick_acc) begin
      s1_use_acc_r <= use_acc;
      s1_hit_r     <= hit;
      s1_accent_r  <= accent_beat;
      s1_beat_r    <= count_r;
      s1_start_r   <= (offset_r == '0);
    end
    if (out_free && s1_v_r) begin
      out_audio_r  <= !s1_hit_r ? 16'sd0 :
                      s1_use_acc_r ? $signed(acc_rd_r) : $signed(clk_rd_r);
      out_accent_r <= s1_accent_r;
      out_beat_r   <= s1_beat_r;
      out_start_r  <= s1_start_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.audio_out   = out_audio_r;
  assign out_ch.is_accent   = out_accent_r;
  assign out_ch.beat_number = out_beat_r;
  assign out_ch.beat_start  = out_start_r;

endmodule

// File: hdl/mcg_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. A start reloads it at once.
module mcg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mcg_pkg::div_req_t req,
  output mcg_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [mcg_pkg::DIV_CNTW-1:0]  cnt_r, cnt_nxt;
  logic [mcg_pkg::DIV_NW-1:0]    quo_r, quo_nxt;
  logic [mcg_pkg::DIV_DW-1:0]    rem_r, rem_nxt;
  logic [mcg_pkg::DIV_DW-1:0]    den_r, den_nxt;
  logic [mcg_pkg::DIV_DW:0]      partial;
  logic [mcg_pkg::DIV_DW:0]      diff;
  logic                          ge;

  always_comb begin
    partial  = {rem_r, quo_r[mcg_pkg::DIV_NW-1]};
    diff     = partial - {1'b0, den_r};
    ge       = partial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[mcg_pkg::DIV_DW-1:0] : partial[mcg_pkg::DIV_DW-1:0];
      quo_nxt = {quo_r[mcg_pkg::DIV_NW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mcg_pkg::DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hdl/mcg_checker.sv
`timescale 1ns / 1ps

module mcg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Period recompute blocks input right after a register write
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken during period recompute");

  // A fresh result follows an accepted tick through stage 1 and the output register
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2) &&
                         ($past(in_req_type, 2) == mcg_pkg::REQ_TICK))
    else $error("result without a tick");

  // Nothing is offered right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind metronome_click_generator_top mcg_checker u_mcg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_we      (cfg_we),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready)
);

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int TBL_DEPTH     = 8192;
  localparam int TBL_FILL      = 32;      // entries loaded at the head of each table
  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 8;       // result trails its tick through the pipeline; a little margin
  localparam int LONG_HOLD     = 300;     // receiver hold-off, long enough to back up the input

  // one item on the input channel
  typedef struct packed {
    logic [1:0]         kind;
    logic [12:0]        idx;
    logic signed [15:0] smp;
  } clip_req_t;

  // one rendered sample on the result channel
  typedef struct packed {
    logic signed [15:0] audio;
    logic               accent;
    logic [5:0]         beat;
    logic               first;
  } click_out_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [mcg_pkg::CFG_IDXW-1:0]  cfg_index;
  logic [mcg_pkg::CFG_DATAW-1:0] cfg_data;

  mcg_in_if  in_ch ();
  mcg_out_if out_ch ();

  metronome_click_generator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the click generator: clip tables, registers, derived periods and
  // the position inside the interval.
  // ---------------------------------------------------------------------------
  logic [15:0] accent_tbl [TBL_DEPTH];
  logic [15:0] click_tbl  [TBL_DEPTH];
  int unsigned tempo, beats_iv, rate, accent_len, click_len;
  bit          sep_accent;
  int unsigned beat_len, iv_len, iv_pos;

  clip_req_t  pending_reqs[$];     // items waiting for the driver
  click_out_t expected_clicks[$];  // predicted samples, oldest first

  int     mismatches    = 0;
  bit     idle_on       = 1'b1;    // random bursts of idling on both sides
  int     hold_requests = 0;       // bumped to ask the receiver for a long hold-off
  longint cycles        = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // beat and interval lengths: exact integer floors on clamped registers
  function automatic void derive_periods();
    longint unsigned b, p, r;
    b = clampu(tempo, mcg_pkg::BPM_MIN, mcg_pkg::BPM_MAX);
    p = clampu(beats_iv, mcg_pkg::BPI_MIN, mcg_pkg::BPI_MAX);
    r = clampu(rate, mcg_pkg::RATE_MIN, mcg_pkg::RATE_MAX);
    beat_len = int'((60 * r) / b);
    iv_len   = int'((p * 60 * r) / b);
  endfunction

  function automatic void set_shadow_reg(logic [mcg_pkg::CFG_IDXW-1:0] idx,
                                         logic [mcg_pkg::CFG_DATAW-1:0] d);
    case (idx)
      mcg_pkg::REG_TEMPO_BPM:    tempo      = d[8:0];
      mcg_pkg::REG_BEATS_PER_IV: beats_iv   = d[6:0];
      mcg_pkg::REG_SAMPLE_RATE:  rate       = d[17:0];
      mcg_pkg::REG_ACCENT_LEN:   accent_len = d[13:0];
      mcg_pkg::REG_CLICK_LEN:    click_len  = d[13:0];
      mcg_pkg::REG_SEP_ACCENT:   sep_accent = d[0];
      default:                   return;
    endcase
    derive_periods();
  endfunction

  // one tick: sample at the current position, then step (wrapping at or past the end)
  function automatic click_out_t render_tick();
    click_out_t  r;
    int unsigned offs, raw, len;
    bit          acc, use_acc;
    offs    = iv_pos % beat_len;
    raw     = iv_pos / beat_len;
    acc     = (raw == 0);
    use_acc = acc && sep_accent;   // accent off: beat zero still flagged, click clip used
    len     = use_acc ? accent_len : click_len;
    if (len > TBL_DEPTH) len = TBL_DEPTH;
    r.audio = '0;
    if (offs < len) r.audio = use_acc ? accent_tbl[offs] : click_tbl[offs];
    r.accent = acc;
    r.beat   = (raw > 63) ? mcg_pkg::BEAT_CNT_MAX : raw[5:0];
    r.first  = (offs == 0);
    iv_pos   = (iv_pos + 1 >= iv_len) ? 0 : iv_pos + 1;
    return r;
  endfunction

  function automatic void apply_req(clip_req_t q);
    case (q.kind)
      mcg_pkg::REQ_WR_ACCENT: if (q.idx < TBL_DEPTH) accent_tbl[q.idx] = q.smp;
      mcg_pkg::REQ_WR_CLICK:  if (q.idx < TBL_DEPTH) click_tbl[q.idx] = q.smp;
      mcg_pkg::REQ_RESTART:   iv_pos = 0;
      default:                expected_clicks.push_back(render_tick());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, applies each one to the shadow on acceptance.
  // ---------------------------------------------------------------------------
  clip_req_t cur_req;
  int        src_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) apply_req(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.req_type    <= cur_req.kind;
          in_ch.clip_index  <= cur_req.idx;
          in_ch.clip_sample <= cur_req.smp;
          if (idle_on && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off, counted down on its own.
  // ---------------------------------------------------------------------------
  int hold_left = 0, holds_served = 0;

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor / receiver: checks each sample against the oldest prediction and
  // drives ready with random stalls plus the long hold-off.
  // ---------------------------------------------------------------------------
  int sink_gap = 0;

  always @(posedge clk) begin
    click_out_t want, got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.audio_out, out_ch.is_accent, out_ch.beat_number, out_ch.beat_start};
        if (expected_clicks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sample: audio=%0d accent=%0b beat=%0d start=%0b",
                     got.audio, got.accent, got.beat, got.first);
        end else begin
          want = expected_clicks.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample mismatch (audio accent beat start): exp %0d %0b %0d %0b, %s",
                       want.audio, want.accent, want.beat, want.first,
                       $sformatf("got %0d %0b %0d %0b",
                                 got.audio, got.accent, got.beat, got.first));
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 9);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [1:0] k, int unsigned idx, int unsigned smp);
    clip_req_t q;
    q.kind = k;
    q.idx  = idx[12:0];
    q.smp  = smp[15:0];
    pending_reqs.push_back(q);
  endtask

  // tick payload fields are don't-care; randomize them anyway
  task automatic push_ticks(int n);
    repeat (n) push_req(mcg_pkg::REQ_TICK, $urandom, $urandom);
  endtask

  // writes stay in the loaded head of the tables so they show up in later samples
  task automatic push_random(int n);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        push_req(mcg_pkg::REQ_TICK, $urandom, $urandom);
      else if (pick < 82)
        push_req(mcg_pkg::REQ_WR_ACCENT, $urandom_range(0, TBL_FILL - 1), $urandom);
      else if (pick < 94)
        push_req(mcg_pkg::REQ_WR_CLICK, $urandom_range(0, TBL_FILL - 1), $urandom);
      else
        push_req(mcg_pkg::REQ_RESTART, $urandom, $urandom);
    end
  endtask

  // checked on the falling edge so driver pops and NBAs have all landed
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_clicks.size() != 0);
  endtask

  // writes and restarts leave no trace on the output, so pad past the pipeline
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write; bits above the register width get junk, which must be dropped
  task automatic write_reg(logic [mcg_pkg::CFG_IDXW-1:0] idx, int unsigned val);
    logic [mcg_pkg::CFG_DATAW-1:0] d;
    int                            w;
    case (idx)
      mcg_pkg::REG_TEMPO_BPM:    w = 9;
      mcg_pkg::REG_BEATS_PER_IV: w = 7;
      mcg_pkg::REG_SAMPLE_RATE:  w = 18;
      mcg_pkg::REG_SEP_ACCENT:   w = 1;
      default:                   w = 14;
    endcase
    d = mcg_pkg::CFG_DATAW'(val) | (mcg_pkg::CFG_DATAW'($urandom) << w);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    set_shadow_reg(idx, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    // periods get recomputed by the serial divider; input ready drops meanwhile
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic set_config(int unsigned bpm, int unsigned bpi, int unsigned sr,
                            int unsigned alen, int unsigned clen, int unsigned sep);
    write_reg(mcg_pkg::REG_TEMPO_BPM, bpm);
    write_reg(mcg_pkg::REG_BEATS_PER_IV, bpi);
    write_reg(mcg_pkg::REG_SAMPLE_RATE, sr);
    write_reg(mcg_pkg::REG_ACCENT_LEN, alen);
    write_reg(mcg_pkg::REG_CLICK_LEN, clen);
    write_reg(mcg_pkg::REG_SEP_ACCENT, sep);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = mcg_pkg::REQ_TICK;
    in_ch.clip_index  = '0;
    in_ch.clip_sample = '0;
    out_ch.ready      = 1'b0;

    tempo      = mcg_pkg::BPM_RST;
    beats_iv   = mcg_pkg::BPI_RST;
    rate       = mcg_pkg::RATE_RST;
    accent_len = 0;
    click_len  = 0;
    sep_accent = 1'b1;
    iv_pos     = 0;
    derive_periods();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config, zero clip lengths: silent samples, beat zero flagged
    push_ticks(2);
    push_req(mcg_pkg::REQ_RESTART, 0, 0);
    push_ticks(2);
    settle();

    // load the head of both tables; clip lengths never reach past it
    idle_on = 1'b0;
    for (int i = 0; i < TBL_FILL; i++) begin
      push_req(mcg_pkg::REQ_WR_ACCENT, i, $urandom);
      push_req(mcg_pkg::REQ_WR_CLICK, i, $urandom);
    end
    // sample extremes at both ends of the loaded part
    push_req(mcg_pkg::REQ_WR_ACCENT, 0, 16'h8000);
    push_req(mcg_pkg::REQ_WR_ACCENT, TBL_FILL - 1, 16'h7fff);
    push_req(mcg_pkg::REQ_WR_CLICK, 0, 16'h7fff);
    push_req(mcg_pkg::REQ_WR_CLICK, TBL_FILL - 1, 16'h8000);
    settle();
    idle_on = 1'b1;

    // 1200-sample beats, two per interval: accent beat, then into the click beat.
    // Long receiver hold-off at the start, sender pause part way.
    set_config(400, 2, 8000, TBL_FILL, 20, 1);
    push_req(mcg_pkg::REQ_RESTART, 0, 0);
    hold_requests++;
    push_ticks(600);
    drain();
    push_ticks(605);
    settle();

    // interval shrinks below the position: render in place, then wrap to zero
    write_reg(mcg_pkg::REG_BEATS_PER_IV, 1);
    push_ticks(3);
    settle();

    // all registers below range: slowest beat; accent length past table depth
    set_config(0, 0, 0, 16383, 0, 1);
    push_req(mcg_pkg::REQ_RESTART, 0, 0);
    push_ticks(20);
    settle();

    // all registers above range, accent disabled so beat zero uses the click clip
    set_config(511, 127, 262143, 0, TBL_FILL, 0);
    push_req(mcg_pkg::REQ_RESTART, 0, 0);
    push_random(20);
    settle();

    // random rounds; position carries across, clip lengths kept in the loaded part
    for (int r = 0; r < 2; r++) begin
      set_config(($urandom_range(0, 1) != 0) ? $urandom_range(300, 511) : $urandom_range(0, 511),
                 $urandom_range(0, 127),
                 ($urandom_range(0, 1) != 0) ? $urandom_range(0, 20000)
                                             : $urandom_range(0, 262143),
                 $urandom_range(0, TBL_FILL),
                 $urandom_range(0, TBL_FILL),
                 $urandom_range(0, 1));
      if (r == 1) idle_on = 1'b0;   // tail of the run at full rate
      push_random(15);
      settle();
    end

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/mcg_pkg.sv
hdl/mcg_if.sv
hdl/mcg_div.sv
hdl/metronome_click_generator_top.sv
hdl/mcg_checker.sv
tb/tb.sv
